// ===== sv/xpf_pkg.sv =====
package xpf_pkg;

    localparam int MAX_SHARD_BYTES = 2048;
    localparam int MAX_DATA_SHARDS = 16;

    localparam int ADDR_W  = $clog2(MAX_SHARD_BYTES);
    localparam int LEN_W   = ADDR_W + 1;
    localparam int SHARD_W = 5;
    localparam int GROUP_W = 32;
    localparam int BYTE_W  = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam int CMD_Q_DEPTH = 4;
    localparam int CMD_Q_AW    = $clog2(CMD_Q_DEPTH);
    localparam int OUT_Q_DEPTH = 2;
    localparam int OUT_Q_AW    = $clog2(OUT_Q_DEPTH);

    localparam logic [SHARD_W-1:0] SHARDS_RESET = SHARD_W'(4);
    localparam logic [GROUP_W-1:0] GROUP_RESET  = '0;

    typedef enum logic {
        OP_DATA  = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_PARITY = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHARDS_PER_GROUP = 1'b0,
        CFG_FIRST_GROUP      = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_kind               kind;
        logic [GROUP_W-1:0]  group;
        logic [SHARD_W-1:0]  shard;
        logic [ADDR_W-1:0]   offset;
        logic [BYTE_W-1:0]   value;
        logic                last;
        logic                ovf;
        logic                wr_en;
        logic                fold;
    } t_cmd;

    typedef struct packed {
        t_kind               kind;
        logic [GROUP_W-1:0]  group;
        logic [SHARD_W-1:0]  shard;
        logic [ADDR_W-1:0]   offset;
        logic [BYTE_W-1:0]   value;
        logic                last;
        logic                ovf;
    } t_res;

endpackage

// ===== sv/xpf_ram.sv =====
module xpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read at the address being written returns the old value
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/xpf_front.sv =====
module xpf_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [xpf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [xpf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_accept,
    input  logic                              i_operation,
    input  logic [xpf_pkg::BYTE_W-1:0]        i_byte_value,
    input  logic                              i_end_of_shard,
    output logic                              o_cmd_valid,
    output xpf_pkg::t_cmd                     o_cmd
);

    localparam logic [xpf_pkg::LEN_W-1:0] MAX_LEN =
        xpf_pkg::LEN_W'(xpf_pkg::MAX_SHARD_BYTES);
    localparam logic [xpf_pkg::SHARD_W-1:0] MAX_SHARDS =
        xpf_pkg::SHARD_W'(xpf_pkg::MAX_DATA_SHARDS);

    logic [xpf_pkg::SHARD_W-1:0] r_shards_cfg;
    logic [xpf_pkg::GROUP_W-1:0] r_group,     n_group;
    logic [xpf_pkg::LEN_W-1:0]   r_byte_pos,  n_byte_pos;
    logic [xpf_pkg::LEN_W-1:0]   r_longest,   n_longest;
    logic [xpf_pkg::SHARD_W-1:0] r_seen,      n_seen;
    logic                        r_draining,  n_draining;
    logic [xpf_pkg::LEN_W-1:0]   r_drain_pos, n_drain_pos;

    logic [xpf_pkg::SHARD_W-1:0] eff_shards;
    logic                        ovf;
    logic [xpf_pkg::LEN_W-1:0]   closed_len;
    logic                        drain_last;
    logic [xpf_pkg::SHARD_W-1:0] seen_inc;

    always_comb begin
        if (r_shards_cfg == '0) begin
            eff_shards = xpf_pkg::SHARD_W'(1);
        end else if (r_shards_cfg > MAX_SHARDS) begin
            eff_shards = MAX_SHARDS;
        end else begin
            eff_shards = r_shards_cfg;
        end
    end

    assign ovf        = r_byte_pos >= MAX_LEN;
    assign closed_len = ovf ? MAX_LEN : r_byte_pos + 1'b1;
    assign drain_last = (r_drain_pos + 1'b1) >= r_longest;
    assign seen_inc   = r_seen + 1'b1;

    always_comb begin
        n_group     = r_group;
        n_byte_pos  = r_byte_pos;
        n_longest   = r_longest;
        n_seen      = r_seen;
        n_draining  = r_draining;
        n_drain_pos = r_drain_pos;
        o_cmd_valid = 1'b0;
        o_cmd       = '0;

        if (i_accept) begin
            if (xpf_pkg::t_op'(i_operation) == xpf_pkg::OP_DATA) begin
                if (!r_draining) begin
                    o_cmd_valid  = 1'b1;
                    o_cmd.kind   = xpf_pkg::KIND_DATA;
                    o_cmd.group  = r_group;
                    o_cmd.shard  = r_seen;
                    o_cmd.offset = ovf ? '0 : r_byte_pos[xpf_pkg::ADDR_W-1:0];
                    o_cmd.value  = i_byte_value;
                    o_cmd.last   = i_end_of_shard;
                    o_cmd.ovf    = ovf;
                    o_cmd.wr_en  = !ovf;
                    // offsets past the longest shard so far are written, not folded
                    o_cmd.fold   = r_byte_pos < r_longest;
                    if (i_end_of_shard) begin
                        if (closed_len > r_longest) begin
                            n_longest = closed_len;
                        end
                        n_byte_pos = '0;
                        n_seen     = seen_inc;
                        if (seen_inc >= eff_shards) begin
                            n_draining  = 1'b1;
                            n_drain_pos = '0;
                        end
                    end else if (!ovf) begin
                        n_byte_pos = r_byte_pos + 1'b1;
                    end
                end
            end else begin
                if (r_draining) begin
                    o_cmd_valid  = 1'b1;
                    o_cmd.kind   = xpf_pkg::KIND_PARITY;
                    o_cmd.group  = r_group;
                    o_cmd.shard  = eff_shards;
                    o_cmd.offset = r_drain_pos[xpf_pkg::ADDR_W-1:0];
                    o_cmd.last   = drain_last;
                    if (drain_last) begin
                        n_draining  = 1'b0;
                        n_drain_pos = '0;
                        n_seen      = '0;
                        n_longest   = '0;
                        n_byte_pos  = '0;
                        n_group     = r_group + 1'b1;
                    end else begin
                        n_drain_pos = r_drain_pos + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shards_cfg <= xpf_pkg::SHARDS_RESET;
            r_group      <= xpf_pkg::GROUP_RESET;
            r_byte_pos   <= '0;
            r_longest    <= '0;
            r_seen       <= '0;
            r_draining   <= 1'b0;
            r_drain_pos  <= '0;
        end else begin
            r_group     <= n_group;
            r_byte_pos  <= n_byte_pos;
            r_longest   <= n_longest;
            r_seen      <= n_seen;
            r_draining  <= n_draining;
            r_drain_pos <= n_drain_pos;
            if (i_cfg_we) begin
                unique case (xpf_pkg::t_cfg_idx'(i_cfg_index))
                    xpf_pkg::CFG_SHARDS_PER_GROUP: begin
                        r_shards_cfg <= i_cfg_data[xpf_pkg::SHARD_W-1:0];
                    end
                    xpf_pkg::CFG_FIRST_GROUP: begin
                        r_group <= i_cfg_data[xpf_pkg::GROUP_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ===== sv/xpf_cmd_q.sv =====
module xpf_cmd_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  xpf_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output xpf_pkg::t_cmd  o_cmd
);

    localparam logic [xpf_pkg::CMD_Q_AW:0] DEPTH_CNT =
        (xpf_pkg::CMD_Q_AW + 1)'(xpf_pkg::CMD_Q_DEPTH);

    xpf_pkg::t_cmd                 r_buf [xpf_pkg::CMD_Q_DEPTH];
    logic [xpf_pkg::CMD_Q_AW-1:0]  r_wp;
    logic [xpf_pkg::CMD_Q_AW-1:0]  r_rp;
    logic [xpf_pkg::CMD_Q_AW:0]    r_cnt;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = r_cnt == DEPTH_CNT;
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_buf[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/xpf_back.sv =====
module xpf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  xpf_pkg::t_cmd  i_cmd,
    output logic           o_cmd_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output xpf_pkg::t_res  o_res
);

    localparam logic [xpf_pkg::OUT_Q_AW:0] OB_FULL =
        (xpf_pkg::OUT_Q_AW + 1)'(xpf_pkg::OUT_Q_DEPTH);

    xpf_pkg::t_cmd                r_s2;
    logic                         r_s2_valid;
    logic                         r_fwd_hit;
    logic [xpf_pkg::BYTE_W-1:0]   r_fwd_data;

    xpf_pkg::t_res                r_ob [xpf_pkg::OUT_Q_DEPTH];
    logic [xpf_pkg::OUT_Q_AW-1:0] r_ob_wp;
    logic [xpf_pkg::OUT_Q_AW-1:0] r_ob_rp;
    logic [xpf_pkg::OUT_Q_AW:0]   r_ob_cnt;

    logic                         s2_fire;
    logic                         issue;
    logic                         ob_pop;
    logic [xpf_pkg::BYTE_W-1:0]   ram_rdata;
    logic [xpf_pkg::BYTE_W-1:0]   mem_data;
    logic [xpf_pkg::BYTE_W-1:0]   new_byte;
    logic                         wr_en;
    xpf_pkg::t_res                res;

    assign s2_fire   = r_s2_valid && (r_ob_cnt != OB_FULL);
    assign issue     = i_cmd_valid && (!r_s2_valid || s2_fire);
    assign o_cmd_pop = issue;
    assign ob_pop    = i_pop && (r_ob_cnt != '0);

    // the read that enters stage two misses the write made on the same edge
    assign mem_data = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign new_byte = r_s2.fold ? (mem_data ^ r_s2.value) : r_s2.value;
    assign wr_en    = s2_fire && r_s2.wr_en;

    xpf_ram #(
        .WIDTH (xpf_pkg::BYTE_W),
        .DEPTH (xpf_pkg::MAX_SHARD_BYTES)
    ) u_parity_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s2.offset),
        .i_wdata (new_byte),
        .i_re    (issue),
        .i_raddr (i_cmd.offset),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        res.kind   = r_s2.kind;
        res.group  = r_s2.group;
        res.shard  = r_s2.shard;
        res.offset = r_s2.offset;
        res.value  = (r_s2.kind == xpf_pkg::KIND_PARITY) ? mem_data : r_s2.value;
        res.last   = r_s2.last;
        res.ovf    = r_s2.ovf;
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s2       <= i_cmd;
            r_fwd_hit  <= wr_en && (r_s2.offset == i_cmd.offset);
            r_fwd_data <= new_byte;
        end
        if (s2_fire) begin
            r_ob[r_ob_wp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_ob_wp    <= '0;
            r_ob_rp    <= '0;
            r_ob_cnt   <= '0;
        end else begin
            if (issue) begin
                r_s2_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_fire) begin
                r_ob_wp <= r_ob_wp + 1'b1;
            end
            if (ob_pop) begin
                r_ob_rp <= r_ob_rp + 1'b1;
            end
            case ({s2_fire, ob_pop})
                2'b10:   r_ob_cnt <= r_ob_cnt + 1'b1;
                2'b01:   r_ob_cnt <= r_ob_cnt - 1'b1;
                default: r_ob_cnt <= r_ob_cnt;
            endcase
        end
    end

    assign o_empty = r_ob_cnt == '0;
    assign o_res   = r_ob[r_ob_rp];

endmodule

// ===== sv/xor_parity_fec_encoder_core.sv =====
// path: a command from an accepted item passes the command queue, the stage-two register and the output buffer
// throughput: one item per cycle while the output buffer has room, set by the parity store fold, a read-modify-write
//   over a registered-read ram with one forwarding register for back-to-back offsets
// reset: synchronous, active low; clears all control state and both queues,
//   loads 4 shards per group and group number 0; the parity store is not cleared
module xor_parity_fec_encoder_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [xpf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [xpf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic                              i_operation,
    input  logic [xpf_pkg::BYTE_W-1:0]        i_byte_value,
    input  logic                              i_end_of_shard,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_kind,
    output logic [xpf_pkg::GROUP_W-1:0]       o_group_number,
    output logic [xpf_pkg::SHARD_W-1:0]       o_shard_number,
    output logic [xpf_pkg::ADDR_W-1:0]        o_byte_offset,
    output logic [xpf_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                              o_last_of_shard,
    output logic                              o_overflow
);

    logic          accept;
    logic          front_valid;
    xpf_pkg::t_cmd front_cmd;
    logic          q_valid;
    logic          q_pop;
    xpf_pkg::t_cmd q_cmd;
    xpf_pkg::t_res res;

    assign accept = push && !full;

    xpf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_operation    (i_operation),
        .i_byte_value   (i_byte_value),
        .i_end_of_shard (i_end_of_shard),
        .o_cmd_valid    (front_valid),
        .o_cmd          (front_cmd)
    );

    xpf_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    xpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (res)
    );

    assign o_kind          = res.kind;
    assign o_group_number  = res.group;
    assign o_shard_number  = res.shard;
    assign o_byte_offset   = res.offset;
    assign o_out_byte      = res.value;
    assign o_last_of_shard = res.last;
    assign o_overflow      = res.ovf;

endmodule

// ===== sv/xpf_chk.sv =====
module xpf_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              full,
    input  logic                              empty,
    input  logic                              o_kind,
    input  logic [xpf_pkg::SHARD_W-1:0]       o_shard_number,
    input  logic [xpf_pkg::ADDR_W-1:0]        o_byte_offset,
    input  logic                              o_overflow
);

    localparam logic [xpf_pkg::SHARD_W-1:0] MAX_SHARDS =
        xpf_pkg::SHARD_W'(xpf_pkg::MAX_DATA_SHARDS);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_parity_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind) |-> !o_overflow)
        else $error("parity item flagged as overflow");

    a_parity_shard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind) |-> (o_shard_number != '0 && o_shard_number <= MAX_SHARDS))
        else $error("parity item shard number out of range");

    a_ovf_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_overflow) |-> (o_byte_offset == '0))
        else $error("overflow item with nonzero offset");

endmodule

bind xor_parity_fec_encoder_core xpf_chk u_xpf_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .o_kind         (o_kind),
    .o_shard_number (o_shard_number),
    .o_byte_offset  (o_byte_offset),
    .o_overflow     (o_overflow)
);
